// ----- rtl/core/ectc_pkg.sv -----
// Shared types, constants and calendar helpers for the epoch-to-calendar converter.
package ectc_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [11:0] NONLEAP_CENT  = 12'd2100;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [8:0]  DAYS_COMMON   = 9'd365;
  localparam logic [3:0]  MONTH_FIRST   = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_LAST    = 4'd12;

  // A day is 675 << 7 seconds; the day count is (secs >> 7) * DAY_RECIP >> 35.
  localparam logic [9:0]  DAY_ODD    = 10'(SECS_PER_DAY >> 7);
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // An hour is 225 << 4 seconds; the hour is (tod >> 4) * HOUR_RECIP >> 21.
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  // A minute is 15 << 2 seconds; the minute is (rest >> 2) * MIN_RECIP >> 14.
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Work handed from the divider front to the calendar walk.
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ectc_work_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DAY,
    FR_TOD,
    FR_HOUR,
    FR_HREM,
    FR_MIN,
    FR_SEC,
    FR_PUSH
  } ectc_front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_YEAR,
    BK_MONTH,
    BK_OUT
  } ectc_back_state_t;

  // Within 1970..2106 the only century year that is not a leap year is 2100.
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != NONLEAP_CENT);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/ectc_front.sv -----
// Front end: accepts a beat and splits it into whole days, hours, minutes and seconds.
module ectc_front
  import ectc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        push_valid,
  input  logic        push_ready,
  output ectc_work_t  push_data
);

  ectc_front_state_t state_r, state_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  logic [50:0] day_prod;
  logic [25:0] day_back;
  logic [25:0] tod_hi;
  logic [25:0] hour_prod;
  logic [16:0] hour_back;
  logic [19:0] min_prod;
  logic [11:0] min_back;

  // Each constant division is a reciprocal multiply, and the remainder comes from
  // a multiply-back in the following cycle, so every step holds one multiplier.
  always_comb begin
    day_prod  = 51'(dvd_r[31:7]) * 51'(DAY_RECIP);
    day_back  = 26'(days_r) * 26'(DAY_ODD);
    tod_hi    = 26'(dvd_r[31:7]) - day_back;
    hour_prod = 26'(rem_r[16:4]) * 26'(HOUR_RECIP);
    hour_back = 17'(hour_r) * SECS_PER_HOUR;
    min_prod  = 20'(rem_r[11:2]) * 20'(MIN_RECIP);
    min_back  = 12'(min_r) * 12'(SECS_PER_MIN);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: if (in_valid) state_nxt = FR_DAY;
      FR_DAY:  state_nxt = FR_TOD;
      FR_TOD:  state_nxt = FR_HOUR;
      FR_HOUR: state_nxt = FR_HREM;
      FR_HREM: state_nxt = FR_MIN;
      FR_MIN:  state_nxt = FR_SEC;
      FR_SEC:  state_nxt = FR_PUSH;
      FR_PUSH: if (push_ready) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    unique case (state_r)
      FR_IDLE: begin
        in_ready = 1'b1;
        dvd_nxt  = in_epoch_seconds;
      end
      FR_DAY:  days_nxt = day_prod[50:35];
      // The low seven bits of the count pass straight into the time of day.
      FR_TOD:  rem_nxt = {tod_hi[9:0], dvd_r[6:0]};
      FR_HOUR: hour_nxt = hour_prod[25:21];
      FR_HREM: rem_nxt = rem_r - hour_back;
      FR_MIN:  min_nxt = min_prod[19:14];
      FR_SEC:  sec_nxt = 6'(rem_r[11:0] - min_back);
      FR_PUSH: push_valid = 1'b1;
      default: ;
    endcase
  end

  assign push_data = '{days: days_r, hour: hour_r, minute: min_r, second: sec_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    days_r <= days_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
  end

endmodule

// ----- rtl/core/ectc_fifo.sv -----
// Short queue that decouples the divider front from the calendar walk.
module ectc_fifo
  import ectc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  ectc_work_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output ectc_work_t pop_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ectc_work_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/ectc_back.sv -----
// Back end: walks years and months off the day count and holds the result beat.
module ectc_back
  import ectc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  ectc_work_t  pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  ectc_back_state_t state_r, state_nxt;
  logic [15:0] days_r, days_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;

  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       year_done;
  logic       month_done;

  always_comb begin
    leap       = is_leap(year_r);
    ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
    mlen       = month_len(month_r, leap);
    year_done  = days_r < {7'd0, ylen};
    month_done = (month_r == MONTH_LAST) || (days_r < {11'd0, mlen});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (pop_valid) state_nxt = BK_YEAR;
      BK_YEAR:  if (year_done) state_nxt = BK_MONTH;
      BK_MONTH: if (month_done) state_nxt = BK_OUT;
      BK_OUT:   if (out_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    out_valid = 1'b0;
    days_nxt  = days_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        days_nxt  = pop_data.days;
        year_nxt  = EPOCH_YEAR;
        month_nxt = MONTH_FIRST;
        hour_nxt  = pop_data.hour;
        min_nxt   = pop_data.minute;
        sec_nxt   = pop_data.second;
      end
      BK_YEAR: begin
        if (!year_done) begin
          days_nxt = 16'(days_r - {7'd0, ylen});
          year_nxt = 12'(year_r + 12'd1);
        end
      end
      BK_MONTH: begin
        if (!month_done) begin
          days_nxt  = 16'(days_r - {11'd0, mlen});
          month_nxt = 4'(month_r + 4'd1);
        end
      end
      BK_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_year   = year_r;
  assign out_month  = month_r;
  assign out_day    = 5'(days_r[4:0] + 5'd1);
  assign out_hour   = hour_r;
  assign out_minute = min_r;
  assign out_second = sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    days_r  <= days_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
  end

endmodule

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
// Top level of the converter from 32-bit epoch seconds to UTC calendar date and time.
//
// Each input beat is a count of seconds since 1970-01-01 00:00:00 UTC and yields exactly one
// result beat with year, month, day, hour, minute and second. The front end splits the count
// with constant reciprocal multiplications, one multiply per cycle: the accept cycle, then
// days, time of day, hour, hour remainder, minute, second and the hand-off. A two-entry queue
// passes the work to the back end, which removes one year per cycle from 1970 with a final
// compare and then one month per cycle, so the back end sets the sustained rate for all but
// the earliest dates. The front end keeps accepting beats while a result waits on out_ready,
// until the queue is full.
module epoch_seconds_to_calendar
  import ectc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  logic       push_valid, push_ready;
  ectc_work_t push_data;
  logic       pop_valid, pop_ready;
  ectc_work_t pop_data;

  ectc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  ectc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ectc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .out_hour   (out_hour),
    .out_minute (out_minute),
    .out_second (out_second)
  );

endmodule

// ----- rtl/core/ectc_checker.sv -----
// Port-level checks on the result channel of the converter, bound to the top level.
module ectc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day) && $stable(out_hour) && $stable(out_minute) && $stable(out_second))
    else $error("result beat changed while stalled");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year >= 12'd1970 && out_year <= 12'd2106)
    else $error("year out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1)
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60)
    else $error("time of day out of range");

endmodule

bind epoch_seconds_to_calendar ectc_checker u_ectc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_year   (out_year),
  .out_month  (out_month),
  .out_day    (out_day),
  .out_hour   (out_hour),
  .out_minute (out_minute),
  .out_second (out_second)
);
